FILE: src/bounded_move_to_front_codec_top_macros.svh
// Assertion helpers used by the codec top module.
`ifndef BOUNDED_MOVE_TO_FRONT_CODEC_TOP_MACROS_SVH
`define BOUNDED_MOVE_TO_FRONT_CODEC_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BMTF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmtf check failed");

// Next-cycle implication, disabled while in reset.
`define BMTF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmtf check failed");

`endif

FILE: src/bmtf_pkg.sv
package bmtf_pkg;

  localparam int SLOTS  = 8;
  localparam int POS_W  = $clog2(SLOTS);
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int CODE_W = 9;
  localparam int BYTE_W = 8;

  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(SLOTS);
  localparam logic [CODE_W-1:0] CODE_BASE = CODE_W'(SLOTS);

  // register byte addresses, bit 2 selects the register index
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic DIR_ENCODE    = 1'b0;
  localparam logic DIR_DECODE    = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CODE_W-1:0] code_t;

  // broadcast to every cell
  typedef struct packed {
    logic              go;
    logic              dec;
    logic              is_pos;
    logic [POS_W-1:0]  pos;
    byte_t             key;
    logic [FILL_W-1:0] fill;
  } cell_ctl_t;

  // search result rippling down the row
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
    byte_t            data;
  } link_t;

endpackage

FILE: src/bmtf_ifs.sv
interface bmtf_in_if import bmtf_pkg::*;;
  logic  valid;
  logic  ready;
  code_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bmtf_out_if import bmtf_pkg::*;;
  logic  valid;
  logic  ready;
  code_t value;
  logic  was_hit;

  modport source (output valid, output value, output was_hit, input ready);
  modport sink   (input valid, input value, input was_hit, output ready);
endinterface

FILE: src/bounded_move_to_front_codec_top.sv
// channel   dir  payload                 handshake
// in_word   in   value[8:0]              valid/ready
// out_word  out  value[8:0], was_hit     valid/ready
// cfg       in   APB, reg 0 direction    psel/penable/pready
//
// One word per cycle: a word is searched and the row updated in its accept cycle.
// The critical path is the compare ripple through the row of cells into cell 0.
// Result sits in an output register; input stalls only while that register is full
// and not being taken. Synchronous active-low reset clears the list, fill count
// and direction; no clearing pass is needed.
`include "bounded_move_to_front_codec_top_macros.svh"

module bounded_move_to_front_codec_top import bmtf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bmtf_in_if.sink      in_word,
  bmtf_out_if.source   out_word,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic              dir_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              out_valid_r;
  code_t             out_value_r;
  logic              out_hit_r;
  logic              in_acc;
  logic              cfg_wr;

  cell_ctl_t         ctl;
  link_t             link [SLOTS+1];
  byte_t             cells [SLOTS];
  byte_t             head_val;
  byte_t             key_byte;
  code_t             lit_code;
  logic              hit;
  code_t             res_value;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DIRECTION) ? {31'b0, dir_r} : 32'b0;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign in_acc        = in_word.valid && in_word.ready;

  assign lit_code = in_word.value - CODE_BASE;
  assign key_byte = (dir_r == DIR_DECODE) ? lit_code[BYTE_W-1:0]
                                          : in_word.value[BYTE_W-1:0];

  always_comb begin
    ctl.go     = in_acc;
    ctl.dec    = (dir_r == DIR_DECODE);
    ctl.is_pos = in_word.value < CODE_BASE;
    ctl.pos    = in_word.value[POS_W-1:0];
    ctl.key    = key_byte;
    ctl.fill   = fill_r;
  end

  assign link[0] = '{found: 1'b0, pos: '0, data: '0};
  assign hit     = link[SLOTS].found;

  // decode of a position takes the stored byte; everything else pushes the key
  assign head_val = (ctl.dec && hit) ? link[SLOTS].data : key_byte;

  for (genvar i = 0; i < SLOTS; i++) begin : g_row
    byte_t left;
    if (i == 0) begin : g_head
      assign left = head_val;
    end else begin : g_body
      assign left = cells[i-1];
    end
    bmtf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cell_idx  (POS_W'(i)),
      .left_byte (left),
      .link_in   (link[i]),
      .link_out  (link[i+1]),
      .cell_byte (cells[i])
    );
  end

  always_comb begin
    if (ctl.dec) begin
      res_value = CODE_W'(head_val);
    end else if (hit) begin
      res_value = CODE_W'(link[SLOTS].pos);
    end else begin
      res_value = CODE_W'(key_byte) + CODE_BASE;
    end
  end

  assign fill_nxt = (in_acc && !hit && fill_r < FILL_MAX) ? fill_r + 1'b1 : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_ENCODE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_DIRECTION) begin
        dir_r <= pwdata[0];
      end
      fill_r <= fill_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_value_r <= res_value;
      out_hit_r   <= hit;
    end
  end

  assign out_word.valid   = out_valid_r;
  assign out_word.value   = out_value_r;
  assign out_word.was_hit = out_hit_r;

  `BMTF_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FILL_MAX)
  `BMTF_ASSERT_NXT(a_acc_gives_result, in_acc, out_valid_r)
  `BMTF_ASSERT_NXT(a_miss_grows_fill, in_acc && !hit && fill_r < FILL_MAX,
                   fill_r == $past(fill_r) + 1'b1)

endmodule

FILE: src/bmtf_cell.sv
module bmtf_cell import bmtf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [POS_W-1:0] cell_idx,
  input  byte_t            left_byte,
  input  link_t            link_in,
  output link_t            link_out,
  output byte_t            cell_byte
);

  byte_t byte_r;
  byte_t byte_nxt;
  logic  filled;
  logic  match;

  assign filled = FILL_W'(cell_idx) < ctl.fill;

  always_comb begin
    if (ctl.dec) begin
      match = ctl.is_pos && (ctl.pos == cell_idx);
    end else begin
      match = filled && (byte_r == ctl.key);
    end
  end

  always_comb begin
    link_out.found = link_in.found | match;
    link_out.pos   = link_in.found ? link_in.pos  : cell_idx;
    link_out.data  = link_in.found ? link_in.data : byte_r;
  end

  // cells up to and including the hit (every cell on a miss) take their left neighbor's byte
  assign byte_nxt = (ctl.go && !link_in.found) ? left_byte : byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign cell_byte = byte_r;

endmodule

FILE: sim/bmtf_code_checker.sv
module bmtf_code_checker import bmtf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  code_t       in_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  code_t       out_value,
  input  logic        out_was_hit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    code_t value;
    logic  was_hit;
  } codec_word_t;

  byte_t       recent [SLOTS];
  int          fill;
  logic        dir_mode;
  codec_word_t due_words [$];

  function automatic void bring_to_front(int pos);
    byte_t v;
    int    k;
    v = recent[pos];
    for (k = pos; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = v;
  endfunction

  function automatic void push_byte(byte_t b);
    int k;
    for (k = SLOTS - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = b;
    if (fill < SLOTS) fill++;
  endfunction

  // updates the list and returns the word the block owes for this input
  function automatic codec_word_t next_codec_word(code_t v);
    codec_word_t w;
    byte_t       b;
    int          p;
    int          hit_pos;
    hit_pos = -1;
    if (dir_mode == DIR_ENCODE) begin
      b = v[BYTE_W-1:0];
      for (p = 0; p < fill; p++) begin
        if (hit_pos < 0 && recent[p] == b) hit_pos = p;
      end
      if (hit_pos >= 0) begin
        bring_to_front(hit_pos);
        w.value   = code_t'(hit_pos);
        w.was_hit = 1'b1;
      end else begin
        push_byte(b);
        w.value   = code_t'(b) + CODE_BASE;
        w.was_hit = 1'b0;
      end
    end else if (v < CODE_BASE) begin
      // unfilled positions are read as they are (zero until pushed that far)
      w.value   = code_t'(recent[v[POS_W-1:0]]);
      w.was_hit = 1'b1;
      bring_to_front(int'(v[POS_W-1:0]));
    end else begin
      b = byte_t'(v - CODE_BASE);
      push_byte(b);
      w.value   = code_t'(b);
      w.was_hit = 1'b0;
    end
    return w;
  endfunction

  always @(posedge clk) begin : watch
    codec_word_t want;
    int          k;
    if (!rst_n) begin
      for (k = 0; k < SLOTS; k++) recent[k] = '0;
      fill     = 0;
      dir_mode = DIR_ENCODE;
      due_words.delete();
      pending_words <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $error("unexpected output word: value %0d was_hit %0d", out_value, out_was_hit);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = due_words.pop_front();
          if (want.value !== out_value || want.was_hit !== out_was_hit) begin
            if (want.value !== out_value)
              $error("out_value: expected %0d, got %0d", want.value, out_value);
            if (want.was_hit !== out_was_hit)
              $error("was_hit: expected %0d, got %0d", want.was_hit, out_was_hit);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready) due_words.push_back(next_codec_word(in_value));
      // only register index 0 exists; bit 2 of the address is the index
      if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION)
        dir_mode = pwdata[0];
      pending_words <= due_words.size();
    end
  end

endmodule

FILE: sim/bounded_move_to_front_codec_top_tb.sv
module bounded_move_to_front_codec_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmtf_pkg::*;

  localparam int          LIMIT_CYCLES   = 200000;
  localparam int          PHASES         = 6;
  localparam int          PHASE_WORDS    = 75;
  localparam int          LONG_HOLD      = 250;
  localparam logic [2:0]  DIRECTION_ADDR = {REG_DIRECTION, 2'b00};
  localparam logic [2:0]  SPARE_ADDR     = 3'b100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pending_words;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit long_hold_req = 1'b0;

  bmtf_in_if  in_word ();
  bmtf_out_if out_word ();

  always #5 clk = ~clk;

  bounded_move_to_front_codec_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  bmtf_code_checker u_codec_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_word.valid),
    .in_ready       (in_word.ready),
    .in_value       (in_word.value),
    .out_valid      (out_word.valid),
    .out_ready      (out_word.ready),
    .out_value      (out_word.value),
    .out_was_hit    (out_word.was_hit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_word(code_t v);
    if (!steady && $urandom_range(0, 2) == 0) begin
      in_word.valid <= 1'b0;
      in_word.value <= code_t'($urandom);
      repeat (gap_len()) @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.value <= v;
    do @(posedge clk); while (!in_word.ready);
  endtask

  task automatic drain();
    in_word.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic code_t pick_encode_word();
    int r;
    r = $urandom_range(0, 9);
    // small alphabet so the list gets hits at every depth
    if (r < 7) return {1'($urandom), byte_t'($urandom_range(0, 11))};
    return code_t'($urandom_range(0, 511));
  endfunction

  function automatic code_t pick_decode_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return code_t'($urandom_range(0, SLOTS - 1));
    if (r < 8) return code_t'($urandom_range(SLOTS, 263));
    return code_t'($urandom_range(0, 511));
  endfunction

  // receiver side
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_word.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_word.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_word.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    logic        dir;
    logic [31:0] data;
    int          ph;
    int          i;
    in_word.valid <= 1'b0;
    in_word.value <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decode straight after reset: unfilled positions, last position, literals
    write_reg(DIRECTION_ADDR, 32'hFFFF_FFFF);
    send_word(code_t'(5));
    send_word(code_t'(SLOTS - 1));
    send_word(code_t'(SLOTS));
    send_word(9'h108);
    send_word(code_t'(263));
    send_word(9'h1FF);
    drain();
    write_reg(SPARE_ADDR, 32'h0000_0000);
    send_word(code_t'(0));
    send_word(code_t'(3));
    drain();

    write_reg(DIRECTION_ADDR, 32'hFFFF_FFFE);
    send_word(9'h000);
    send_word(9'h0FF);
    send_word(9'h1FF);
    send_word(9'h100);
    for (i = 0; i < SLOTS; i++) send_word(code_t'(8'h10 + i));
    send_word(9'h010);
    send_word(9'h1AA);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      dir  = (ph % 2 == 0) ? DIR_DECODE : DIR_ENCODE;
      data = $urandom;
      data[0] = dir;
      if (ph == PHASES - 1) data = {31'h7FFF_FFFF, dir};
      write_reg(DIRECTION_ADDR, data);
      if (ph == 3) write_reg(SPARE_ADDR, $urandom);
      steady = (ph == 2) || ($urandom_range(0, 3) == 0);
      if (ph == 2) long_hold_req = 1'b1;
      for (i = 0; i < PHASE_WORDS; i++)
        send_word(dir == DIR_ENCODE ? pick_encode_word() : pick_decode_word());
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
